// ----- rtl/bpc_pkg.sv -----
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation pipe.
// ---------------------------------------------------------------------------
package bpc_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNCAL = 2'd1;
    localparam logic [1:0] ST_ZDIV  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP   = 3'd0;
    localparam logic [2:0] CFG_PRES_A = 3'd1;
    localparam logic [2:0] CFG_PRES_B = 3'd2;
    localparam logic [2:0] CFG_PRES_C = 3'd3;
    localparam logic [2:0] CFG_LOADED = 3'd4;

    // fine temperature range
    localparam logic signed [24:0] TF_MAX = 25'sd1048575;
    localparam logic signed [24:0] TF_MIN = -25'sd1048576;

    localparam logic signed [21:0] A_OFS = 22'sd128000;
    localparam logic [20:0]        P_OFS = 21'd1048576;
    localparam logic signed [57:0] X_OFS = 58'sd140737488355328; // 1 << 47

    // quotient bits resolved by the divider, one per stage
    localparam int DIV_STEPS = 64;

    // calibration words
    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic               loaded;
    } t_cal;

    // temperature unit -> pressure front end
    typedef struct packed {
        logic signed [20:0] tf;
        logic [1:0]         status;
        logic [19:0]        raw_p;
    } t_tmp;

    // pressure front end -> divider
    typedef struct packed {
        logic signed [20:0] tf;
        logic [1:0]         status;
        logic signed [63:0] dvd;
        logic signed [30:0] dvs;
    } t_dvin;

    // divider -> pressure back end
    typedef struct packed {
        logic signed [20:0] tf;
        logic [1:0]         status;
        logic [63:0]        quo;
        logic               neg;
    } t_dvout;

endpackage

// ----- rtl/bpc_temp.sv -----
// ---------------------------------------------------------------------------
// bpc_temp
// Four-stage fine temperature pipe with saturation to 21 bits.
// ---------------------------------------------------------------------------
module bpc_temp import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_raw_p,
    input  logic [19:0] i_raw_t,
    output logic        o_valid,
    input  logic        i_ready,
    output t_tmp        o_data
);

    localparam int NS = 4;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    logic signed [17:0] n_d, r_d;
    logic signed [16:0] n_e, r_e;
    logic signed [33:0] r_dt2, r_ee;
    logic signed [22:0] r_v1;
    logic signed [37:0] r_eet3;
    logic signed [23:0] v2;
    logic signed [24:0] sum;
    logic signed [20:0] tf;
    logic [1:0]  r_st0, r_st1, r_st2;
    logic [19:0] r_p0, r_p1, r_p2;
    t_tmp        r_out;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // raw differences
    assign n_d = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
    assign n_e = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_cal.t1});

    // final sum and saturation
    always_comb begin
        v2  = $signed(r_eet3[37:14]);
        sum = r_v1 + v2;
        if (sum > TF_MAX)      tf = TF_MAX[20:0];
        else if (sum < TF_MIN) tf = TF_MIN[20:0];
        else                   tf = sum[20:0];
        if (r_st2 != ST_OK)    tf = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d   <= n_d;
            r_e   <= n_e;
            r_st0 <= i_cal.loaded ? ST_OK : ST_UNCAL;
            r_p0  <= i_raw_p;
        end
        if (en[1]) begin
            r_dt2 <= r_d * i_cal.t2;
            r_ee  <= r_e * r_e;
            r_st1 <= r_st0;
            r_p1  <= r_p0;
        end
        if (en[2]) begin
            r_v1   <= $signed(r_dt2[33:11]);
            r_eet3 <= $signed(r_ee[33:12]) * i_cal.t3;
            r_st2  <= r_st1;
            r_p2   <= r_p1;
        end
        if (en[3]) begin
            r_out.tf     <= tf;
            r_out.status <= r_st2;
            r_out.raw_p  <= r_p2;
        end
    end

endmodule

// ----- rtl/bpc_var.sv -----
// ---------------------------------------------------------------------------
// bpc_var
// Pressure front end: builds the 64-bit dividend and the divisor.
// ---------------------------------------------------------------------------
module bpc_var import bpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cal  i_cal,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_tmp  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_dvin o_data
);

    localparam int NS = 7;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    logic signed [20:0] r_tf [NS];
    logic [1:0]         r_st [NS];

    logic signed [21:0] n_a, r_a;
    logic [20:0]        r_pm0, r_pm1, r_pm2, r_pm3;
    logic signed [41:0] r_aa;
    logic signed [37:0] r_ap5, r_ap2, r_ap5b, r_ap2b;
    logic signed [57:0] r_aap6, r_aap3;
    logic signed [59:0] r_b;
    logic signed [57:0] x_full;
    logic signed [51:0] r_x;
    logic [41:0]        r_xl;
    logic signed [42:0] r_xh;
    logic signed [60:0] n_n, r_n;
    logic [63:0]        prod, n64, m, r_m, r_dvd;
    logic signed [30:0] var1, r_dvs, r_dvs6;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign n_a    = i_data.tf - A_OFS;
    assign x_full = (r_aap3 >>> 8) + (r_ap2b <<< 12) + X_OFS;
    assign n_n    = $signed({9'd0, r_pm3, 31'd0}) - r_b;

    // low 64 bits of x * P1, then the divisor; dividend times 125
    always_comb begin
        prod = {r_xh[37:0], 26'd0} + {22'd0, r_xl};
        var1 = $signed(prod[63:33]);
        n64  = {{3{r_n[60]}}, r_n};
        m    = (n64 << 7) - (n64 << 2) + n64;
    end

    // tag fields ride along; a zero divisor is flagged entering stage 5
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tf[0] <= i_data.tf;
            r_st[0] <= i_data.status;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_tf[k] <= r_tf[k-1];
                if (k == 5 && r_st[4] == ST_OK && var1 == '0) begin
                    r_st[k] <= ST_ZDIV;
                end else begin
                    r_st[k] <= r_st[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a   <= n_a;
            r_pm0 <= P_OFS - {1'b0, i_data.raw_p};
        end
        if (en[1]) begin
            r_aa  <= r_a * r_a;
            r_ap5 <= r_a * i_cal.p5;
            r_ap2 <= r_a * i_cal.p2;
            r_pm1 <= r_pm0;
        end
        if (en[2]) begin
            r_aap6 <= r_aa * i_cal.p6;
            r_aap3 <= r_aa * i_cal.p3;
            r_ap5b <= r_ap5;
            r_ap2b <= r_ap2;
            r_pm2  <= r_pm1;
        end
        if (en[3]) begin
            r_b   <= r_aap6 + (r_ap5b <<< 17) + (i_cal.p4 <<< 35);
            r_x   <= x_full[51:0];
            r_pm3 <= r_pm2;
        end
        if (en[4]) begin
            r_xl <= r_x[25:0] * i_cal.p1;
            r_xh <= $signed(r_x[51:26]) * $signed({1'b0, i_cal.p1});
            r_n  <= n_n;
        end
        if (en[5]) begin
            r_dvs <= var1;
            r_m   <= m;
        end
        // divisor rides along with the finished dividend
        if (en[6]) begin
            r_dvd  <= (r_m << 4) + (r_m << 3) + r_m;
            r_dvs6 <= r_dvs;
        end
    end

    assign o_data.tf     = r_tf[NS-1];
    assign o_data.status = r_st[NS-1];
    assign o_data.dvd    = $signed(r_dvd);
    assign o_data.dvs    = r_dvs6;

endmodule

// ----- rtl/bpc_div.sv -----
// ---------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider: magnitudes in, one quotient bit per stage.
// ---------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_dvin  i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_dvout o_data
);

    localparam int NS = DIV_STEPS + 1;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    logic [63:0]        r_qd  [NS];
    logic [30:0]        r_rem [NS];
    logic [30:0]        r_dm  [NS];
    logic               r_neg [NS];
    logic signed [20:0] r_tf  [NS];
    logic [1:0]         r_st  [NS];

    logic [63:0] n_qd  [DIV_STEPS];
    logic [30:0] n_rem [DIV_STEPS];
    logic [63:0] dv;
    logic [30:0] ds;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // one trial subtraction per stage
    always_comb begin
        logic [31:0] t;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {r_rem[k], r_qd[k][63]};
            if (t >= {1'b0, r_dm[k]}) begin
                n_rem[k] = 31'(t - {1'b0, r_dm[k]});
                n_qd[k]  = {r_qd[k][62:0], 1'b1};
            end else begin
                n_rem[k] = t[30:0];
                n_qd[k]  = {r_qd[k][62:0], 1'b0};
            end
        end
    end

    assign dv = i_data.dvd;
    assign ds = i_data.dvs;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_qd[0]  <= dv[63] ? (~dv + 64'd1) : dv;
            r_dm[0]  <= ds[30] ? (~ds + 31'd1) : ds;
            r_rem[0] <= '0;
            r_neg[0] <= dv[63] ^ ds[30];
            r_tf[0]  <= i_data.tf;
            r_st[0]  <= i_data.status;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_qd[k]  <= n_qd[k-1];
                r_rem[k] <= n_rem[k-1];
                r_dm[k]  <= r_dm[k-1];
                r_neg[k] <= r_neg[k-1];
                r_tf[k]  <= r_tf[k-1];
                r_st[k]  <= r_st[k-1];
            end
        end
    end

    assign o_data.tf     = r_tf[NS-1];
    assign o_data.status = r_st[NS-1];
    assign o_data.quo    = r_qd[NS-1];
    assign o_data.neg    = r_neg[NS-1];

endmodule

// ----- rtl/bpc_post.sv -----
// ---------------------------------------------------------------------------
// bpc_post
// Pressure back end: P7..P9 correction, Q24.8 scaling and saturation.
// ---------------------------------------------------------------------------
module bpc_post import bpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cal               i_cal,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_dvout             i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_pressure,
    output logic signed [20:0] o_tf,
    output logic [1:0]         o_status
);

    localparam int NS = 8;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    logic signed [20:0] r_tf [NS];
    logic [1:0]         r_st [NS];

    logic signed [63:0] r_p0, r_p1, r_p2, r_p3, r_p4;
    logic [63:0]        s1, s2;
    logic signed [48:0] r_l9, r_l8;
    logic [31:0]        r_h9, r_h8;
    logic [47:0]        h9, h8;
    logic [63:0]        m1, b8, r_m1, r_ll, c1, c2;
    logic [31:0]        r_c1, r_c2;
    logic signed [63:0] r_b2, r_b3, r_b4, r_m2, r_t, r_r;
    logic [31:0]        r_pres;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // products kept modulo 2^64 from 32-bit halves
    always_comb begin
        s1 = {{13{r_p0[63]}}, r_p0[63:13]};
        s2 = {{13{r_p2[63]}}, r_p2[63:13]};
        h9 = 48'(i_cal.p9 * $signed(s1[63:32]));
        h8 = 48'(i_cal.p8 * $signed(r_p0[63:32]));
        m1 = {r_h9, 32'd0} + {{15{r_l9[48]}}, r_l9};
        b8 = {r_h8, 32'd0} + {{15{r_l8[48]}}, r_l8};
        c1 = r_m1[63:32] * s2[31:0];
        c2 = r_m1[31:0] * s2[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tf[0] <= i_data.tf;
            r_st[0] <= i_data.status;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_tf[k] <= r_tf[k-1];
                r_st[k] <= r_st[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p0 <= i_data.neg ? $signed(64'd0 - i_data.quo) : $signed(i_data.quo);
        end
        if (en[1]) begin
            r_l9 <= i_cal.p9 * $signed({1'b0, s1[31:0]});
            r_h9 <= h9[31:0];
            r_l8 <= i_cal.p8 * $signed({1'b0, r_p0[31:0]});
            r_h8 <= h8[31:0];
            r_p1 <= r_p0;
        end
        if (en[2]) begin
            r_m1 <= m1;
            r_b2 <= $signed(b8) >>> 19;
            r_p2 <= r_p1;
        end
        if (en[3]) begin
            r_ll <= r_m1[31:0] * s2[31:0];
            r_c1 <= c1[31:0];
            r_c2 <= c2[31:0];
            r_b3 <= r_b2;
            r_p3 <= r_p2;
        end
        if (en[4]) begin
            r_m2 <= $signed(r_ll + {r_c1 + r_c2, 32'd0});
            r_b4 <= r_b3;
            r_p4 <= r_p3;
        end
        if (en[5]) begin
            r_t <= r_p4 + (r_m2 >>> 25) + r_b4;
        end
        if (en[6]) begin
            r_r <= (r_t >>> 8) + (i_cal.p7 <<< 4);
        end
        if (en[7]) begin
            if (r_st[6] != ST_OK || r_r[63]) r_pres <= '0;
            else if (|r_r[62:32])            r_pres <= '1;
            else                             r_pres <= r_r[31:0];
        end
    end

    assign o_pressure = r_pres;
    assign o_tf       = r_tf[NS-1];
    assign o_status   = r_st[NS-1];

endmodule

// ----- rtl/barometric_pressure_compensation_unit.sv -----
// ---------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Fine temperature and 64-bit integer pressure compensation, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready    | i_raw_pressure, i_raw_temperature
//  output   | o_out_valid / i_out_ready  | o_pressure_q24_8, o_fine_temperature,
//           |                            | o_status
//  config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
//  One transaction per cycle sustained while the output is not held; the
//  divider resolves one quotient bit per stage, between the arithmetic stages.
//  Synchronous active-low reset clears all stage valid bits and the
//  calibration registers. A held output stalls only stages that are full;
//  empty stages keep filling, so no transaction is lost or repeated.
// ---------------------------------------------------------------------------
module barometric_pressure_compensation_unit import bpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_pressure_q24_8,
    output logic signed [20:0] o_fine_temperature,
    output logic [1:0]         o_status
);

    logic [47:0] r_temp_cf, r_pa_cf, r_pb_cf, r_pc_cf;
    logic        r_loaded;
    t_cal        cal;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cf <= '0;
            r_pa_cf   <= '0;
            r_pb_cf   <= '0;
            r_pc_cf   <= '0;
            r_loaded  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:   r_temp_cf <= i_cfg_data;
                CFG_PRES_A: r_pa_cf   <= i_cfg_data;
                CFG_PRES_B: r_pb_cf   <= i_cfg_data;
                CFG_PRES_C: r_pc_cf   <= i_cfg_data;
                CFG_LOADED: r_loaded  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // unpack calibration words
    always_comb begin
        cal.t1     = r_temp_cf[15:0];
        cal.t2     = $signed(r_temp_cf[31:16]);
        cal.t3     = $signed(r_temp_cf[47:32]);
        cal.p1     = r_pa_cf[15:0];
        cal.p2     = $signed(r_pa_cf[31:16]);
        cal.p3     = $signed(r_pa_cf[47:32]);
        cal.p4     = $signed(r_pb_cf[15:0]);
        cal.p5     = $signed(r_pb_cf[31:16]);
        cal.p6     = $signed(r_pb_cf[47:32]);
        cal.p7     = $signed(r_pc_cf[15:0]);
        cal.p8     = $signed(r_pc_cf[31:16]);
        cal.p9     = $signed(r_pc_cf[47:32]);
        cal.loaded = r_loaded;
    end

    logic   tmp_valid, tmp_ready, var_valid, var_ready, div_valid, div_ready;
    t_tmp   tmp_data;
    t_dvin  var_data;
    t_dvout div_data;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_raw_p (i_raw_pressure),
        .i_raw_t (i_raw_temperature),
        .o_valid (tmp_valid),
        .i_ready (tmp_ready),
        .o_data  (tmp_data)
    );

    bpc_var u_var (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_valid (tmp_valid),
        .o_ready (tmp_ready),
        .i_data  (tmp_data),
        .o_valid (var_valid),
        .i_ready (var_ready),
        .o_data  (var_data)
    );

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (var_valid),
        .o_ready (var_ready),
        .i_data  (var_data),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_data)
    );

    bpc_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cal      (cal),
        .i_valid    (div_valid),
        .o_ready    (div_ready),
        .i_data     (div_data),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_pressure (o_pressure_q24_8),
        .o_tf       (o_fine_temperature),
        .o_status   (o_status)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for barometric_pressure_compensation_unit. A local
// model of the fine temperature and 64-bit pressure math predicts each
// result. Reading pairs go in through directed and random tests under several
// calibration sets, with random idle and stall cycles on both channels.
// ---------------------------------------------------------------------------
module tb;
    import bpc_pkg::*;

    localparam int LATENCY = 84;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0]        pres;
        logic signed [20:0] tf;
        logic [1:0]         status;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [19:0]        i_raw_pressure = '0;
    logic [19:0]        i_raw_temperature = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [31:0]        o_pressure_q24_8;
    logic signed [20:0] o_fine_temperature;
    logic [1:0]         o_status;

    // calibration copy held by the bench
    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic        cal_loaded;

    t_reading pending_readings[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    barometric_pressure_compensation_unit i_dut (.*);

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic longint sword(logic [47:0] r, int sh);
        logic [15:0] w;
        w = r[sh +: 16];
        return longint'($signed(w));
    endfunction

    function automatic longint uword(logic [47:0] r, int sh);
        return longint'({48'd0, r[sh +: 16]});
    endfunction

    // truncating signed divide, most negative / -1 wraps to itself
    function automatic longint trunc_div(longint n, longint dv);
        logic [63:0] mn, md, q;
        mn = (n < 0) ? 64'(-n) : 64'(n);
        md = (dv < 0) ? 64'(-dv) : 64'(dv);
        q  = mn / md;
        return ((n < 0) != (dv < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_reading compensate(logic [19:0] rp, logic [19:0] rt);
        t_reading r;
        longint t1, t2, t3, d, e, v1, v2, tf, a, b, p;
        if (!cal_loaded) begin
            r.pres = '0; r.tf = '0; r.status = ST_UNCAL;
            return r;
        end
        t1 = uword(cal_temp, 0);
        t2 = sword(cal_temp, 16);
        t3 = sword(cal_temp, 32);
        d  = longint'(rt >> 3) - (t1 << 1);
        v1 = (d * t2) >>> 11;
        e  = longint'(rt >> 4) - t1;
        v2 = (((e * e) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        if (tf > 1048575) tf = 1048575;
        if (tf < -1048576) tf = -1048576;
        r.tf = tf[20:0];
        // pressure, all 64-bit wrapping
        a = tf - 128000;
        b = a * a * sword(cal_pb, 32);
        b = b + ((a * sword(cal_pb, 16)) << 17);
        b = b + (sword(cal_pb, 0) << 35);
        a = ((a * a * sword(cal_pa, 32)) >>> 8) + ((a * sword(cal_pa, 16)) << 12);
        a = (((longint'(1) << 47) + a) * uword(cal_pa, 0)) >>> 33;
        if (a == 0) begin
            r.pres = '0; r.status = ST_ZDIV;
            return r;
        end
        p = 1048576 - longint'(rp);
        p = trunc_div(((p << 31) - b) * 3125, a);
        a = (sword(cal_pc, 32) * (p >>> 13) * (p >>> 13)) >>> 25;
        b = (sword(cal_pc, 16) * p) >>> 19;
        p = ((p + a + b) >>> 8) + (sword(cal_pc, 0) << 4);
        if (p < 0) r.pres = '0;
        else if (p > longint'(32'hFFFF_FFFF)) r.pres = 32'hFFFF_FFFF;
        else r.pres = p[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    // output side: check each transaction, then pick next ready
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result: p=%0h tf=%0d st=%0d",
                       o_pressure_q24_8, o_fine_temperature, o_status);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_pressure_q24_8 !== want.pres) begin
                    $error("pressure_q24_8: expected %0h actual %0h",
                           want.pres, o_pressure_q24_8);
                    fail_count++;
                end
                if (o_fine_temperature !== want.tf) begin
                    $error("fine_temperature: expected %0d actual %0d",
                           want.tf, o_fine_temperature);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one input transaction; valid stays high between back-to-back items
    task automatic send_reading(logic [19:0] rp, logic [19:0] rt);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= rp;
        i_raw_temperature <= rt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(compensate(rp, rt));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // load all registers while the pipe is idle; index 5 must be ignored
    task automatic load_cal(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc, logic ld);
        logic [47:0] vals[5];
        vals = '{t, pa, pb, pc, {47'd0, ld}};
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= (k == CFG_LOADED)
                          ? (48'({$urandom, $urandom}) & ~48'd1) | {47'd0, ld}
                          : vals[k];
            @(posedge i_clk);
        end
        i_cfg_idx  <= 3'd5;
        i_cfg_data <= 48'({$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cal_temp = t; cal_pa = pa; cal_pb = pb; cal_pc = pc; cal_loaded = ld;
        @(posedge i_clk);
    endtask

    // typical factory calibration
    task automatic load_typical(logic ld);
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855},
                 {16'd6000, 16'hC6F8, 16'd15500}, ld);
    endtask

    task automatic test_uncalibrated();
        load_typical(1'b0);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd415148, 20'd519888);
        drain();
    endtask

    task automatic test_directed();
        logic [19:0] corners[4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
        load_typical(1'b1);
        foreach (corners[i])
            foreach (corners[j]) send_reading(corners[i], corners[j]);
        send_reading(20'd415148, 20'd519888);
        drain();
        // zero coefficients give a zero divisor
        load_cal('0, '0, '0, '0, 1'b1);
        send_reading(20'd415148, 20'd519888);
        send_reading(20'hFFFFF, 20'h00000);
        drain();
        // extreme coefficients drive fine temperature and pressure to saturation
        load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {48'h8000_8000_8000}, {48'h7FFF_7FFF_7FFF}, 1'b1);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        drain();
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {48'h7FFF_7FFF_7FFF}, {48'h8000_8000_8000}, 1'b1);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        drain();
    endtask

    task automatic random_batch(int n);
        int pidle[4] = '{0, 59, 0, 21};
        int pstall[4] = '{0, 0, 59, 21};
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = pidle[m];
            recv_stall_pct = pstall[m];
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(3) == 0)
                    send_reading(20'($urandom), 20'($urandom));
                else
                    send_reading(20'($urandom_range(500000, 200000)),
                                 20'($urandom_range(600000, 400000)));
            end
        end
    endtask

    task automatic test_random();
        logic [47:0] t, pa, pb, pc;
        // typical and perturbed calibration, then fully random words
        load_typical(1'b1);
        random_batch(70);
        drain();
        for (int s = 0; s < 5; s++) begin
            t  = {16'($urandom_range(3000) - 1500), 16'($urandom_range(30000, 20000)),
                  16'($urandom_range(30000, 25000))};
            pa = {16'($urandom_range(4000, 2000)), 16'(-$urandom_range(12000, 9000)),
                  16'($urandom_range(40000, 32000))};
            pb = {16'($urandom_range(20) - 10), 16'($urandom_range(300)),
                  16'($urandom_range(4000, 2000))};
            pc = {16'($urandom_range(8000, 4000)), 16'(-$urandom_range(16000, 12000)),
                  16'($urandom_range(17000, 14000))};
            load_cal(t, pa, pb, pc, 1'b1);
            random_batch(60);
            drain();
        end
        load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 1'b1);
        random_batch(40);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_loaded = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_uncalibrated();
        test_directed();
        test_random();
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
